FILE: sv/c2s_pkg.sv
package c2s_pkg;

  localparam int COORD_WIDTH_DEF   = 24;
  localparam int CORDIC_STAGES_DEF = 18;
  localparam int GUARD_BITS        = 16;
  localparam int ACC_W             = 27;
  localparam int ANG_W             = 18;
  localparam int AZ_W              = 20;
  localparam int RAD_W             = 24;
  localparam int OUT_DATA_W        = 64;

  localparam logic [ANG_W-1:0] HALF_PI_Q = 18'd102944;
  localparam logic [ANG_W-1:0] PI_Q      = 18'd205887;
  localparam logic [AZ_W-1:0]  TWO_PI_Q  = 20'd411775;

  typedef struct packed {
    logic x_pos;
    logic x_zero;
    logic y_pos;
    logic y_zero;
    logic z_pos;
    logic z_zero;
  } sign_flags_t;

  // atan(2^-i) in radians * 2^24
  function automatic logic signed [ACC_W-1:0] atan_tab(input int idx);
    logic signed [ACC_W-1:0] v;
    v = '0;
    case (idx)
      0:  v = 27'sd13176795;
      1:  v = 27'sd7778716;
      2:  v = 27'sd4110060;
      3:  v = 27'sd2086331;
      4:  v = 27'sd1047214;
      5:  v = 27'sd524117;
      6:  v = 27'sd262123;
      7:  v = 27'sd131069;
      8:  v = 27'sd65536;
      9:  v = 27'sd32768;
      10: v = 27'sd16384;
      11: v = 27'sd8192;
      12: v = 27'sd4096;
      13: v = 27'sd2048;
      14: v = 27'sd1024;
      15: v = 27'sd512;
      16: v = 27'sd256;
      17: v = 27'sd128;
      18: v = 27'sd64;
      19: v = 27'sd32;
      20: v = 27'sd16;
      21: v = 27'sd8;
      22: v = 27'sd4;
      23: v = 27'sd2;
      24: v = 27'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/c2s_delay.sv
module c2s_delay import c2s_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] line_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      line_r[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        line_r[i] <= line_r[i-1];
      end
    end
  end

  assign dout = line_r[DEPTH-1];

endmodule

FILE: sv/c2s_isqrt.sv
module c2s_isqrt import c2s_pkg::*; #(
  parameter int W = COORD_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           en,
  input  logic [2*W-1:0] rad,
  output logic [W-1:0]   root
);

  localparam int RW = W + 3;

  logic [RW-1:0]  rem_r  [W];
  logic [W-1:0]   root_r [W];
  logic [2*W-1:0] rad_r  [W];

  // one root bit per stage, two radicand bits brought down each time
  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [RW-1:0]  p_rem;
    logic [W-1:0]   p_root;
    logic [2*W-1:0] p_rad;
    logic [RW-1:0]  rem_in;
    logic [RW-1:0]  trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_rad  = rad;
    end else begin : g_next
      assign p_rem  = rem_r[k-1];
      assign p_root = root_r[k-1];
      assign p_rad  = rad_r[k-1];
    end

    assign rem_in = {p_rem[RW-4:0], p_rad[2*W-1:2*W-2]};
    assign trial  = {1'b0, p_root, 2'b01};
    assign ge     = rem_in >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? rem_in - trial : rem_in;
        root_r[k] <= {p_root[W-2:0], ge};
        rad_r[k]  <= {p_rad[2*W-3:0], 2'b00};
      end
    end
  end

  assign root = root_r[W-1];

endmodule

FILE: sv/c2s_cordic.sv
module c2s_cordic import c2s_pkg::*; #(
  parameter int W = COORD_WIDTH_DEF,
  parameter int N = CORDIC_STAGES_DEF
) (
  input  logic             clk,
  input  logic             en,
  input  logic [W-1:0]     a,
  input  logic [W-1:0]     b,
  output logic [ANG_W-1:0] q
);

  localparam int DW = W + GUARD_BITS + 3;

  logic signed [DW-1:0]    px_r  [N];
  logic signed [DW-1:0]    py_r  [N];
  logic signed [ACC_W-1:0] acc_r [N];
  logic                    zero_r [N];
  logic [ANG_W-1:0]        q_r;

  for (genvar i = 0; i < N; i++) begin : g_iter
    logic signed [DW-1:0]    p_x;
    logic signed [DW-1:0]    p_y;
    logic signed [ACC_W-1:0] p_acc;
    logic                    p_zero;
    logic signed [DW-1:0]    sx;
    logic signed [DW-1:0]    sy;

    if (i == 0) begin : g_first
      assign p_x    = signed'(DW'(b) << GUARD_BITS);
      assign p_y    = signed'(DW'(a) << GUARD_BITS);
      assign p_acc  = '0;
      assign p_zero = (a == '0);
    end else begin : g_next
      assign p_x    = px_r[i-1];
      assign p_y    = py_r[i-1];
      assign p_acc  = acc_r[i-1];
      assign p_zero = zero_r[i-1];
    end

    assign sx = p_x >>> i;
    assign sy = p_y >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[i] <= p_zero;
        if (!p_y[DW-1]) begin
          px_r[i]  <= p_x + sy;
          py_r[i]  <= p_y - sx;
          acc_r[i] <= p_acc + atan_tab(i);
        end else begin
          px_r[i]  <= p_x - sy;
          py_r[i]  <= p_y + sx;
          acc_r[i] <= p_acc - atan_tab(i);
        end
      end
    end
  end

  logic [ACC_W-1:0] acc_pos;
  logic [ACC_W:0]   acc_rnd;
  logic [ANG_W-1:0] q_nxt;

  // clamp below at zero, round half up to 2^-16, clamp above at pi/2; zero when a is zero
  always_comb begin
    acc_pos = acc_r[N-1][ACC_W-1] ? '0 : unsigned'(acc_r[N-1]);
    acc_rnd = ({1'b0, acc_pos} + (ACC_W+1)'(128)) >> 8;
    if (zero_r[N-1]) begin
      q_nxt = '0;
    end else if (acc_rnd > (ACC_W+1)'(HALF_PI_Q)) begin
      q_nxt = HALF_PI_Q;
    end else begin
      q_nxt = acc_rnd[ANG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

FILE: sv/cartesian_to_spherical.sv
// Cartesian to spherical converter, fully pipelined.
// The pipeline is made up mainly of the square root stages (one bit per stage)
// and the CORDIC iteration stages.
// Throughput: one point per cycle; a stall on the output freezes the whole pipe.
// Reset (rst_n, synchronous, active low) clears only the stage valid bits.
module cartesian_to_spherical import c2s_pkg::*; #(
  parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
  parameter int IN_DATA_W     = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // coord_x, coord_y, coord_z, COORD_WIDTH bits each, from bit 0 up
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // radius[23:0], polar_angle[41:24], azimuth[61:42], zero fill above
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int W     = COORD_WIDTH;
  localparam int N     = CORDIC_STAGES;
  localparam int LAT   = W + N + 5;
  localparam int SW    = $bits(sign_flags_t);
  localparam int D1    = W + 2;
  localparam int D2    = N + 1;

  logic en;
  logic [LAT-1:0] vld_r;

  assign en         = !out_tvalid || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // stage 1: magnitudes and sign flags
  logic signed [W-1:0] cx, cy, cz;
  logic [W-1:0] ax_r, ay_r, az_r;
  sign_flags_t  flg_r;

  assign cx = signed'(in_tdata[W-1:0]);
  assign cy = signed'(in_tdata[2*W-1:W]);
  assign cz = signed'(in_tdata[3*W-1:2*W]);

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r <= cx[W-1] ? unsigned'(-cx) : unsigned'(cx);
      ay_r <= cy[W-1] ? unsigned'(-cy) : unsigned'(cy);
      az_r <= cz[W-1] ? unsigned'(-cz) : unsigned'(cz);
      flg_r.x_pos  <= !cx[W-1] && (cx != '0);
      flg_r.x_zero <= (cx == '0);
      flg_r.y_pos  <= !cy[W-1] && (cy != '0);
      flg_r.y_zero <= (cy == '0);
      flg_r.z_pos  <= !cz[W-1] && (cz != '0);
      flg_r.z_zero <= (cz == '0);
    end
  end

  // stage 2: squares; stage 3: sums
  logic [2*W-1:0] sqx_r, sqy_r, sqz_r, rho_sq_r, tot_sq_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r    <= (2*W)'(ax_r) * (2*W)'(ax_r);
      sqy_r    <= (2*W)'(ay_r) * (2*W)'(ay_r);
      sqz_r    <= (2*W)'(az_r) * (2*W)'(az_r);
      rho_sq_r <= sqx_r + sqy_r;
      tot_sq_r <= sqx_r + sqy_r + sqz_r;
    end
  end

  logic [W-1:0] rho, radius_full;

  c2s_isqrt #(.W(W)) u_sqrt_rho (
    .clk  (clk),
    .en   (en),
    .rad  (rho_sq_r),
    .root (rho)
  );

  c2s_isqrt #(.W(W)) u_sqrt_rad (
    .clk  (clk),
    .en   (en),
    .rad  (tot_sq_r),
    .root (radius_full)
  );

  // hold magnitudes and flags until the roots come out
  logic [3*W+SW-1:0] side_d;
  logic [W-1:0] ax_d, ay_d, az_d;
  sign_flags_t  flg_d;

  c2s_delay #(.WIDTH(3*W+SW), .DEPTH(D1)) u_side_dly (
    .clk  (clk),
    .en   (en),
    .din  ({flg_r, az_r, ay_r, ax_r}),
    .dout (side_d)
  );

  assign ax_d  = side_d[W-1:0];
  assign ay_d  = side_d[2*W-1:W];
  assign az_d  = side_d[3*W-1:2*W];
  assign flg_d = sign_flags_t'(side_d[3*W+SW-1:3*W]);

  logic [ANG_W-1:0] q_pol, q_az;

  c2s_cordic #(.W(W), .N(N)) u_cordic_pol (
    .clk (clk),
    .en  (en),
    .a   (rho),
    .b   (az_d),
    .q   (q_pol)
  );

  c2s_cordic #(.W(W), .N(N)) u_cordic_az (
    .clk (clk),
    .en  (en),
    .a   (ay_d),
    .b   (ax_d),
    .q   (q_az)
  );

  logic [RAD_W+SW-1:0] tail_d;
  logic [RAD_W-1:0]    radius_d;
  sign_flags_t         flg_q;

  c2s_delay #(.WIDTH(RAD_W+SW), .DEPTH(D2)) u_tail_dly (
    .clk  (clk),
    .en   (en),
    .din  ({flg_d, RAD_W'(radius_full)}),
    .dout (tail_d)
  );

  assign radius_d = tail_d[RAD_W-1:0];
  assign flg_q    = sign_flags_t'(tail_d[RAD_W+SW-1:RAD_W]);

  // quadrant selection
  logic [ANG_W-1:0] polar_nxt;
  logic [AZ_W-1:0]  azim_nxt;
  logic [AZ_W-1:0]  q_az_w;

  assign q_az_w = AZ_W'(q_az);

  always_comb begin
    if (flg_q.z_zero) begin
      polar_nxt = HALF_PI_Q;
    end else if (flg_q.z_pos) begin
      polar_nxt = q_pol;
    end else begin
      polar_nxt = PI_Q - q_pol;
    end

    if (flg_q.x_pos) begin
      if (flg_q.y_pos) begin
        azim_nxt = q_az_w;
      end else if (!flg_q.y_zero) begin
        azim_nxt = TWO_PI_Q - q_az_w;
      end else begin
        azim_nxt = '0;
      end
    end else if (flg_q.x_zero) begin
      if (flg_q.y_pos) begin
        azim_nxt = AZ_W'(HALF_PI_Q);
      end else if (!flg_q.y_zero) begin
        azim_nxt = -AZ_W'(HALF_PI_Q);
      end else begin
        azim_nxt = '0;
      end
    end else begin
      if (flg_q.y_pos || flg_q.y_zero) begin
        azim_nxt = AZ_W'(PI_Q) - q_az_w;
      end else begin
        azim_nxt = AZ_W'(PI_Q) + q_az_w;
      end
    end
  end

  logic [OUT_DATA_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= OUT_DATA_W'({azim_nxt, polar_nxt, radius_d});
    end
  end

  assign out_tdata = out_data_r;

endmodule
